// File: sv/khs_pkg.sv
// ----------------------------------------------------------------------------
// khs_pkg
// Shared constants, keyword table and command type for the keyword
// highlighting stream.
// ----------------------------------------------------------------------------
package khs_pkg;

  // Default sizes of the block.
  localparam int KeywordCountDef = 7;
  localparam int HoldDepthDef    = 6;

  // Sizes of the keyword table and of one command.
  localparam int KwTableSize = 16;
  localparam int KwMaxLen    = 6;
  localparam int MaxResults  = 16;
  localparam int HoldMax     = 16;
  localparam int NumW        = 5;

  // Input kinds.
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Special characters.
  localparam logic [7:0] CHAR_SHARP = 8'h23;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  // Keyword text, padded with zero bytes.
  localparam logic [7:0] KW_TEXT [KwTableSize][KwMaxLen] = '{
    '{8'h76, 8'h6f, 8'h69, 8'h64, 8'h00, 8'h00},  // void
    '{8'h69, 8'h6e, 8'h74, 8'h00, 8'h00, 8'h00},  // int
    '{8'h63, 8'h68, 8'h61, 8'h72, 8'h00, 8'h00},  // char
    '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00},  // if
    '{8'h66, 8'h6f, 8'h72, 8'h00, 8'h00, 8'h00},  // for
    '{8'h77, 8'h68, 8'h69, 8'h6c, 8'h65, 8'h00},  // while
    '{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6e},  // return
    '{default: 8'h00}, '{default: 8'h00}, '{default: 8'h00},
    '{default: 8'h00}, '{default: 8'h00}, '{default: 8'h00},
    '{default: 8'h00}, '{default: 8'h00}, '{default: 8'h00}
  };

  localparam int KW_LEN [KwTableSize] = '{
    4, 3, 4, 2, 3, 5, 6, 0, 0, 0, 0, 0, 0, 0, 0, 0
  };

  // Color escape sequences placed around a keyword.
  localparam logic [7:0] ESC_BLUE [5]  = '{8'h1b, 8'h5b, 8'h33, 8'h34, 8'h6d};
  localparam logic [7:0] ESC_RESET [4] = '{8'h1b, 8'h5b, 8'h30, 8'h6d};
  localparam int EscBlueLen  = 5;
  localparam int EscResetLen = 4;

  // One output burst, as handed from the front end to the back end:
  // optional blue prefix, held bytes, optional reset suffix, optional tail.
  typedef struct packed {
    logic            kw;
    logic [NumW-1:0] cnt;
    logic            has_tail;
    logic [7:0]      tail_byte;
    logic            eoc;
    logic [NumW-1:0] num;
  } cmd_t;

endpackage

// File: sv/khs_if.sv
// ----------------------------------------------------------------------------
// khs_in_if / khs_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface khs_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] in_byte;

  modport source (output valid, output kind, output in_byte, input ready);
  modport sink   (input valid, input kind, input in_byte, output ready);
endinterface

interface khs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       last_of_run;
  logic       end_of_command;

  modport source (output valid, output out_byte, output has_byte,
                  output last_of_run, output end_of_command, input ready);
  modport sink   (input valid, input out_byte, input has_byte,
                  input last_of_run, input end_of_command, output ready);
endinterface

// File: sv/keyword_highlight_stream.sv
// ----------------------------------------------------------------------------
// keyword_highlight_stream
// Highlights C keywords in a character stream, with sharp-delimited drops.
// ----------------------------------------------------------------------------
// Path: the results of an item pass through the command queue and then the
// output register. Throughput: one input item per cycle while the two-entry
// command queue has room; the back end sets the pace at one result byte, and
// so one result of an item, per cycle while the output is ready.
// Reset: drop mode, held count and pass-through clear at once; no sweep.
// ----------------------------------------------------------------------------
module keyword_highlight_stream #(
  parameter int KEYWORD_COUNT = khs_pkg::KeywordCountDef,
  parameter int HOLD_DEPTH    = khs_pkg::HoldDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  khs_in_if.sink    in_i,
  khs_out_if.source out_o
);
  import khs_pkg::*;

  localparam int CmdW  = $bits(cmd_t);
  localparam int FifoW = CmdW + HOLD_DEPTH * 8;

  cmd_t                    front_cmd, back_cmd;
  logic [HOLD_DEPTH*8-1:0] front_held, back_held;
  logic [FifoW-1:0]        rdata;
  logic                    push, pop, full, empty;

  khs_front #(
    .KEYWORD_COUNT (KEYWORD_COUNT),
    .HOLD_DEPTH    (HOLD_DEPTH)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (front_cmd),
    .held_o (front_held)
  );

  khs_cmd_fifo #(
    .WIDTH (FifoW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({front_cmd, front_held}),
    .pop_i   (pop),
    .rdata_o (rdata),
    .full_o  (full),
    .empty_o (empty)
  );

  assign back_cmd  = rdata[FifoW-1 -: CmdW];
  assign back_held = rdata[HOLD_DEPTH*8-1:0];

  khs_back #(
    .HOLD_DEPTH (HOLD_DEPTH)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (back_cmd),
    .held_i  (back_held),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// File: sv/khs_front.sv
// ----------------------------------------------------------------------------
// khs_front
// Accepts characters, tracks drop mode and the held token, detects keywords
// and issues one output burst command per transaction that produces output.
// ----------------------------------------------------------------------------
module khs_front #(
  parameter int KEYWORD_COUNT = khs_pkg::KeywordCountDef,
  parameter int HOLD_DEPTH    = khs_pkg::HoldDepthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  khs_in_if.sink                  in_i,
  input  logic                    full_i,
  output logic                    push_o,
  output khs_pkg::cmd_t           cmd_o,
  output logic [HOLD_DEPTH*8-1:0] held_o
);
  import khs_pkg::*;

  localparam int CntW = $clog2(HOLD_DEPTH + 1);

  logic            drop_q, drop_d;
  logic            pt_q, pt_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      held_q [HOLD_DEPTH];
  logic [7:0]      held_ext [KwMaxLen];
  logic            held_we;
  logic            acc;
  logic            tok_live;
  logic            kw_hit;
  logic [5:0]      sum;

  assign in_i.ready = !full_i;
  assign acc        = in_i.valid && !full_i;
  assign tok_live   = (cnt_q != '0) || pt_q;

  // Held bytes widened to the longest keyword for comparison.
  for (genvar g = 0; g < KwMaxLen; g++) begin : g_ext
    if (g < HOLD_DEPTH) begin : g_on
      assign held_ext[g] = held_q[g];
    end else begin : g_off
      assign held_ext[g] = CHAR_NUL;
    end
  end

  for (genvar g = 0; g < HOLD_DEPTH; g++) begin : g_flat
    assign held_o[g*8 +: 8] = held_q[g];
  end

  // Keyword match against the held token.
  always_comb begin
    logic eq;
    kw_hit = 1'b0;
    for (int k = 0; k < KEYWORD_COUNT && k < KwTableSize; k++) begin
      eq = (int'(cnt_q) == KW_LEN[k]) && (cnt_q != '0);
      for (int i = 0; i < KwMaxLen; i++) begin
        if (int'(cnt_q) > i && held_ext[i] != KW_TEXT[k][i]) begin
          eq = 1'b0;
        end
      end
      kw_hit = kw_hit | eq;
    end
  end

  // Classification of the accepted transaction.
  always_comb begin
    drop_d  = drop_q;
    pt_d    = pt_q;
    cnt_d   = cnt_q;
    held_we = 1'b0;
    push_o  = 1'b0;
    cmd_o.kw        = 1'b0;
    cmd_o.cnt       = '0;
    cmd_o.has_tail  = 1'b1;
    cmd_o.tail_byte = in_i.in_byte;
    cmd_o.eoc       = 1'b0;
    if (acc) begin
      if (in_i.kind == KIND_END) begin
        push_o    = 1'b1;
        cmd_o.eoc = 1'b1;
        if (tok_live) begin
          cmd_o.kw        = !pt_q && kw_hit;
          cmd_o.cnt       = NumW'(cnt_q);
          cmd_o.tail_byte = CHAR_SPACE;
        end else begin
          cmd_o.has_tail  = 1'b0;
          cmd_o.tail_byte = CHAR_NUL;
        end
        drop_d = 1'b0;
        cnt_d  = '0;
        pt_d   = 1'b0;
      end else if (in_i.in_byte == CHAR_SHARP) begin
        drop_d = !drop_q;
      end else if (drop_q || in_i.in_byte == CHAR_NUL) begin
        // Dropped characters produce nothing.
      end else if (in_i.in_byte == CHAR_SPACE) begin
        push_o          = tok_live;
        cmd_o.kw        = !pt_q && kw_hit;
        cmd_o.cnt       = NumW'(cnt_q);
        cmd_o.tail_byte = CHAR_SPACE;
        cnt_d = '0;
        pt_d  = 1'b0;
      end else if (pt_q) begin
        push_o = 1'b1;
      end else if (cnt_q < CntW'(HOLD_DEPTH)) begin
        held_we = 1'b1;
        cnt_d   = cnt_q + CntW'(1);
      end else begin
        // Token outgrew the hold buffer: spill it and pass through.
        push_o    = 1'b1;
        cmd_o.cnt = NumW'(HOLD_DEPTH);
        cnt_d = '0;
        pt_d  = 1'b1;
      end
    end
    sum = (cmd_o.kw ? 6'(EscBlueLen + EscResetLen) : 6'd0) + 6'(cmd_o.cnt)
          + 6'(cmd_o.has_tail);
    cmd_o.num = (sum > 6'(MaxResults)) ? NumW'(MaxResults) : sum[NumW-1:0];
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_q <= 1'b0;
      pt_q   <= 1'b0;
      cnt_q  <= '0;
    end else begin
      drop_q <= drop_d;
      pt_q   <= pt_d;
      cnt_q  <= cnt_d;
    end
  end

  // Held token bytes.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < HOLD_DEPTH; i++) begin
      if (held_we && cnt_q == CntW'(i)) begin
        held_q[i] <= in_i.in_byte;
      end
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cnt_q) <= HOLD_DEPTH)
    else $error("held count beyond hold depth");

  a_pt_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pt_q |-> (cnt_q == '0))
    else $error("pass-through mode with held characters");

endmodule

// File: sv/khs_cmd_fifo.sv
// ----------------------------------------------------------------------------
// khs_cmd_fifo
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module khs_cmd_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);
  logic [WIDTH-1:0] mem_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       count_q;

  assign full_o  = count_q == 2'd2;
  assign empty_o = count_q == 2'd0;
  assign rdata_o = mem_q[rptr_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
      count_q <= count_q + 2'(push_i) - 2'(pop_i);
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o) && !(pop_i && empty_o))
    else $error("command queue overrun or underrun");

endmodule

// File: sv/khs_back.sv
// ----------------------------------------------------------------------------
// khs_back
// Expands the command at the head of the queue into result bytes, one per
// cycle while the output is ready, into an output register.
// ----------------------------------------------------------------------------
module khs_back #(
  parameter int HOLD_DEPTH = khs_pkg::HoldDepthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  khs_pkg::cmd_t           cmd_i,
  input  logic [HOLD_DEPTH*8-1:0] held_i,
  input  logic                    empty_i,
  output logic                    pop_o,
  khs_out_if.source               out_o
);
  import khs_pkg::*;

  logic [3:0]      k_q;
  logic            valid_q;
  logic [7:0]      byte_q, byte_d;
  logic            has_q, last_q, eoc_q;
  logic            last_d;
  logic            adv, load;
  logic [NumW-1:0] j, j2;

  assign adv  = !valid_q || out_o.ready;
  assign load = adv && !empty_i;
  assign last_d = (cmd_i.num == '0) || ((NumW'(k_q) + NumW'(1)) == cmd_i.num);
  assign pop_o  = load && last_d;

  // Byte at position k of the burst.
  always_comb begin
    j      = NumW'(k_q) - (cmd_i.kw ? NumW'(EscBlueLen) : '0);
    j2     = j - cmd_i.cnt;
    byte_d = cmd_i.tail_byte;
    if (cmd_i.kw && k_q < 4'(EscBlueLen)) begin
      byte_d = ESC_BLUE[k_q[2:0]];
    end else if (j < cmd_i.cnt) begin
      byte_d = CHAR_NUL;
      for (int i = 0; i < HOLD_DEPTH; i++) begin
        if (j == NumW'(i)) begin
          byte_d = held_i[i*8 +: 8];
        end
      end
    end else if (cmd_i.kw && j2 < NumW'(EscResetLen)) begin
      byte_d = ESC_RESET[j2[1:0]];
    end
  end

  // Position counter and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q     <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        k_q     <= last_d ? 4'd0 : k_q + 4'd1;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_d;
      has_q  <= cmd_i.num != '0;
      last_q <= last_d;
      eoc_q  <= last_d && cmd_i.eoc;
    end
  end

  assign out_o.valid          = valid_q;
  assign out_o.out_byte       = byte_q;
  assign out_o.has_byte       = has_q;
  assign out_o.last_of_run    = last_q;
  assign out_o.end_of_command = eoc_q;

  a_bare_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !has_q) |-> (eoc_q && last_q && byte_q == CHAR_NUL))
    else $error("bare marker without end of command");

  a_eoc_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && eoc_q) |-> last_q)
    else $error("end of command on a result that is not last");

endmodule

// File: sim/tb_keyword_highlight_stream.sv
// ----------------------------------------------------------------------------
// tb_keyword_highlight_stream
// Self-checking testbench for the keyword highlighting stream. A short list
// of hand-written commands comes first, and then randomly built command lines
// with some noise. Every accepted input transaction is run through a
// behavioral model of the highlighter, and every output transaction is
// compared field by field with the oldest predicted result. Both channels
// idle in random bursts, and once the output holds off long enough to stall
// the input.
// ----------------------------------------------------------------------------
module tb_keyword_highlight_stream;
  timeunit 1ns;
  timeprecision 1ps;

  import khs_pkg::*;

  // One output character, as seen on the output channel.
  typedef struct packed {
    logic [7:0] ch;
    logic       has;
    logic       last;
    logic       eoc;
  } hl_out_t;

  // One input item, with an optional expectation typed in by hand.
  typedef struct packed {
    logic       kind;
    logic [7:0] ch;
    logic       typed;
    logic       one_res;
    hl_out_t    res;
  } cmd_item_t;

  localparam int RandomTarget = 395;
  localparam int CalmTail     = 60;
  localparam int StallLimit   = 2000;
  localparam int PressureAt   = 120;
  localparam int PressureLen  = 80;
  localparam int DrainCycles  = 16;

  localparam hl_out_t NO_RES   = '0;
  localparam hl_out_t BARE_END = '{8'h00, 1'b0, 1'b1, 1'b1};

  // Hand-written commands. Rows with typed set carry their own expectation.
  localparam cmd_item_t DIRECTED [25] = '{
    '{KIND_END,  8'h00,      1'b1, 1'b1, BARE_END},  // empty command after reset
    '{KIND_CHAR, "i",        1'b1, 1'b0, NO_RES},
    '{KIND_CHAR, "f",        1'b1, 1'b0, NO_RES},
    '{KIND_CHAR, CHAR_SPACE, 1'b0, 1'b0, NO_RES},    // keyword gets wrapped
    '{KIND_CHAR, CHAR_SHARP, 1'b1, 1'b0, NO_RES},    // enter drop mode
    '{KIND_CHAR, CHAR_SPACE, 1'b1, 1'b0, NO_RES},    // dropped space
    '{KIND_CHAR, "x",        1'b1, 1'b0, NO_RES},
    '{KIND_CHAR, CHAR_SHARP, 1'b1, 1'b0, NO_RES},    // leave drop mode
    '{KIND_CHAR, 8'hff,      1'b1, 1'b0, NO_RES},
    '{KIND_CHAR, 8'h01,      1'b1, 1'b0, NO_RES},
    '{KIND_CHAR, 8'h80,      1'b1, 1'b0, NO_RES},
    '{KIND_CHAR, 8'h09,      1'b1, 1'b0, NO_RES},    // a tab is part of the token
    '{KIND_CHAR, "a",        1'b1, 1'b0, NO_RES},
    '{KIND_CHAR, "b",        1'b1, 1'b0, NO_RES},    // hold buffer now full
    '{KIND_CHAR, "z",        1'b0, 1'b0, NO_RES},    // overflow releases the token
    '{KIND_CHAR, "q",        1'b1, 1'b1, '{"q", 1'b1, 1'b1, 1'b0}},
    '{KIND_CHAR, CHAR_NUL,   1'b1, 1'b0, NO_RES},    // zero byte is ignored
    '{KIND_CHAR, CHAR_SPACE, 1'b1, 1'b1, '{CHAR_SPACE, 1'b1, 1'b1, 1'b0}},
    '{KIND_CHAR, CHAR_SHARP, 1'b1, 1'b0, NO_RES},    // sharp left unmatched
    '{KIND_END,  8'hff,      1'b1, 1'b1, BARE_END},
    '{KIND_CHAR, "f",        1'b1, 1'b0, NO_RES},
    '{KIND_CHAR, "o",        1'b1, 1'b0, NO_RES},
    '{KIND_CHAR, "r",        1'b1, 1'b0, NO_RES},
    '{KIND_END,  8'h00,      1'b0, 1'b0, NO_RES},    // end flushes a keyword
    '{KIND_END,  8'h7f,      1'b1, 1'b1, BARE_END}
  };

  logic clk;
  logic rst_n;

  khs_in_if  in_if ();
  khs_out_if out_if ();

  keyword_highlight_stream dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Keyword list and the color sequences that wrap a keyword.
  string      kw_words [7] = '{"void", "int", "char", "if", "for", "while", "return"};
  logic [7:0] blue_seq [5] = '{8'h1b, "[", "3", "4", "m"};
  logic [7:0] plain_seq [4] = '{8'h1b, "[", "0", "m"};

  // State of the behavioral model.
  logic       drop_on;
  logic [7:0] held_buf [HoldDepthDef];
  int         held_len;
  logic       pass_thru;

  cmd_item_t  stim_q [$];
  hl_out_t    expected_q [$];
  int         n_taken;
  int         n_errors;
  bit         calm;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void push_item(input logic kind, input logic [7:0] ch);
    stim_q.push_back('{kind, ch, 1'b0, 1'b0, NO_RES});
  endfunction

  function automatic void emit_byte(ref hl_out_t q[$], input logic [7:0] b);
    if (q.size() < MaxResults) q.push_back('{b, 1'b1, 1'b0, 1'b0});
  endfunction

  // Release the held token, wrapped in color if it is a keyword.
  function automatic void flush_word(ref hl_out_t q[$]);
    bit is_kw;
    bit same;
    if (held_len == 0 && !pass_thru) return;
    is_kw = 1'b0;
    if (!pass_thru) begin
      foreach (kw_words[k]) begin
        if (kw_words[k].len() == held_len) begin
          same = 1'b1;
          for (int i = 0; i < held_len; i++) begin
            if (kw_words[k][i] != held_buf[i]) same = 1'b0;
          end
          if (same) is_kw = 1'b1;
        end
      end
    end
    if (is_kw) foreach (blue_seq[i]) emit_byte(q, blue_seq[i]);
    for (int i = 0; i < held_len; i++) emit_byte(q, held_buf[i]);
    if (is_kw) foreach (plain_seq[i]) emit_byte(q, plain_seq[i]);
    emit_byte(q, CHAR_SPACE);
    held_len  = 0;
    pass_thru = 1'b0;
  endfunction

  // Work out the output characters caused by one input transaction.
  function automatic void predict_highlight(input logic kind, input logic [7:0] ch,
                                            ref hl_out_t q[$]);
    q = {};
    if (kind == KIND_END) begin
      flush_word(q);
      if (q.size() == 0) q.push_back(NO_RES);
      q[q.size()-1].eoc = 1'b1;
      drop_on   = 1'b0;
      held_len  = 0;
      pass_thru = 1'b0;
    end else if (ch == CHAR_SHARP) begin
      drop_on = ~drop_on;
    end else if (drop_on || ch == CHAR_NUL) begin
      // Nothing comes out.
    end else if (ch == CHAR_SPACE) begin
      flush_word(q);
    end else if (pass_thru) begin
      emit_byte(q, ch);
    end else if (held_len < HoldDepthDef) begin
      held_buf[held_len] = ch;
      held_len++;
    end else begin
      for (int i = 0; i < HoldDepthDef; i++) emit_byte(q, held_buf[i]);
      emit_byte(q, ch);
      held_len  = 0;
      pass_thru = 1'b1;
    end
    if (q.size() > 0) q[q.size()-1].last = 1'b1;
  endfunction

  // Random command lines: tokens between runs of spaces, mostly keywords and
  // near misses, with some drop sections; now and then plain noise.
  function automatic void add_random_commands();
    string      near_miss [10] = '{"in", "ints", "fo", "voi", "chars", "whilee",
                                   "retur", "returns", "iff", "If"};
    string      word;
    int         n_tok;
    logic [7:0] c;
    while (stim_q.size() < $size(DIRECTED) + RandomTarget) begin
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 12)) begin
          push_item(($urandom_range(0, 9) == 0) ? KIND_END : KIND_CHAR,
                    8'($urandom_range(1, 255)));
        end
      end else begin
        n_tok = $urandom_range(1, 5);
        for (int t = 0; t < n_tok; t++) begin
          repeat ($urandom_range((t == 0) ? 0 : 1, 3)) push_item(KIND_CHAR, CHAR_SPACE);
          case ($urandom_range(0, 9))
            0, 1, 2, 3: word = kw_words[$urandom_range(0, 6)];
            4, 5:       word = near_miss[$urandom_range(0, 9)];
            default:    word = "";
          endcase
          if (word.len() == 0) begin
            repeat ($urandom_range(1, 10)) begin
              c = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(8'h61, 8'h7a))
                                              : 8'($urandom_range(1, 255));
              if (c == CHAR_SPACE || c == CHAR_SHARP) c = "_";
              push_item(KIND_CHAR, c);
            end
          end else begin
            for (int i = 0; i < word.len(); i++) push_item(KIND_CHAR, word[i]);
          end
          // Drop section, sometimes left open until the end of the command.
          if ($urandom_range(0, 7) == 0) begin
            push_item(KIND_CHAR, CHAR_SHARP);
            repeat ($urandom_range(0, 5)) begin
              c = 8'($urandom_range(1, 255));
              if (c == CHAR_SHARP) c = CHAR_SPACE;
              push_item(KIND_CHAR, c);
            end
            if ($urandom_range(0, 3) != 0) push_item(KIND_CHAR, CHAR_SHARP);
          end
        end
        repeat ($urandom_range(0, 2)) push_item(KIND_CHAR, CHAR_SPACE);
        push_item(KIND_END, 8'($urandom_range(0, 255)));
      end
    end
  endfunction

  task automatic flag_error(input string what, input int unsigned got_v,
                            input int unsigned exp_v);
    n_errors++;
    $display("%0t: %s: got %0h, expected %0h", $realtime, what, got_v, exp_v);
  endtask

  // Prediction on each input transaction, comparison on each output one.
  always @(posedge clk) begin : scoreboard
    hl_out_t fresh [$];
    hl_out_t got;
    hl_out_t want;
    if (in_if.valid && in_if.ready) begin
      predict_highlight(in_if.kind, in_if.in_byte, fresh);
      if (stim_q[n_taken].typed) begin
        fresh = {};
        if (stim_q[n_taken].one_res) fresh.push_back(stim_q[n_taken].res);
      end
      foreach (fresh[i]) expected_q.push_back(fresh[i]);
      n_taken++;
    end
    if (out_if.valid && out_if.ready) begin
      got = '{out_if.out_byte, out_if.has_byte, out_if.last_of_run,
              out_if.end_of_command};
      if (expected_q.size() == 0) begin
        flag_error("output with nothing expected, out_byte", got.ch, 0);
      end else begin
        want = expected_q.pop_front();
        if (got.ch !== want.ch)     flag_error("out_byte", got.ch, want.ch);
        if (got.has !== want.has)   flag_error("has_byte", got.has, want.has);
        if (got.last !== want.last) flag_error("last_of_run", got.last, want.last);
        if (got.eoc !== want.eoc)   flag_error("end_of_command", got.eoc, want.eoc);
      end
    end
  end

  // Output side: random hold-off bursts, plus one long hold that backs the
  // block up into its input.
  initial begin
    bit pressed;
    pressed = 1'b0;
    out_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!pressed && n_taken >= PressureAt) begin
        pressed = 1'b1;
        out_if.ready <= 1'b0;
        repeat (PressureLen - 1) @(posedge clk);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(0, 5)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("[keyword_highlight_stream] ERROR");
    $finish;
  end

  // Reset, input side and end of run.
  initial begin
    drop_on   = 1'b0;
    held_len  = 0;
    pass_thru = 1'b0;
    n_taken   = 0;
    n_errors  = 0;
    calm      = 1'b0;
    rst_n           <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.kind      <= KIND_CHAR;
    in_if.in_byte   <= 8'h00;
    foreach (DIRECTED[i]) stim_q.push_back(DIRECTED[i]);
    add_random_commands();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < stim_q.size(); i++) begin
      calm = (i >= stim_q.size() - CalmTail);
      if (!calm && $urandom_range(0, 4) == 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      in_if.valid   <= 1'b1;
      in_if.kind    <= stim_q[i].kind;
      in_if.in_byte <= stim_q[i].ch;
      do @(posedge clk); while (!(in_if.valid && in_if.ready));
    end
    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("[keyword_highlight_stream] OK");
    end else begin
      $display("[keyword_highlight_stream] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/khs_pkg.sv
sv/khs_if.sv
sv/khs_front.sv
sv/khs_cmd_fifo.sv
sv/khs_back.sv
sv/keyword_highlight_stream.sv
sim/tb_keyword_highlight_stream.sv
